@@ hdl/qsl_pkg.sv @@
// package for the quaternion slerp / lerp pipeline: payload types, fixed-point
// constants, cordic angle table and the shared square-root and cordic step functions
// no dependencies
`default_nettype none

package qsl_pkg;

   localparam int FracBits    = 14;
   localparam int AngleFrac   = 30;
   localparam int CordicSteps = 30;
   localparam int RootBits    = 31;
   localparam int QuotBits    = 16;
   localparam int OneQ16      = 65536;
   localparam int D30Shift    = AngleFrac - 2 * FracBits;
   localparam logic [34:0] Thresh =
      35'((64'd1 << (2 * FracBits)) - ((64'd1 << (2 * FracBits)) / 200000));

   localparam int TopStages  = 5 + (RootBits + 1) + (CordicSteps + 1) + 1
                               + (CordicSteps + 1) + 2;
   localparam int NormStages = 7 + (RootBits + 1) + (QuotBits + 1) + 1;
   localparam int Latency    = TopStages + NormStages;

   localparam logic [31:0] AtanTable [CordicSteps] = '{
      32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159, 32'd67021687,
      32'd33543516, 32'd16775851, 32'd8388437, 32'd4194283, 32'd2097149,
      32'd1048576, 32'd524288, 32'd262144, 32'd131072, 32'd65536, 32'd32768,
      32'd16384, 32'd8192, 32'd4096, 32'd2048, 32'd1024, 32'd512, 32'd256,
      32'd128, 32'd64, 32'd32, 32'd16, 32'd8, 32'd4, 32'd2
   };

   typedef struct packed {
      logic        [16:0] fraction;
      logic signed [15:0] from_w;
      logic signed [15:0] from_x;
      logic signed [15:0] from_y;
      logic signed [15:0] from_z;
      logic signed [15:0] to_w;
      logic signed [15:0] to_x;
      logic signed [15:0] to_y;
      logic signed [15:0] to_z;
   } req_type;

   typedef struct packed {
      logic signed [15:0] out_w;
      logic signed [15:0] out_x;
      logic signed [15:0] out_y;
      logic signed [15:0] out_z;
   } rsp_type;

   // one item in flight: saturated t, start and (sign-fixed) end, path select
   typedef struct packed {
      logic [16:0]       t;
      logic [3:0][15:0]  a;
      logic [3:0][16:0]  b;
      logic              sph;
   } work_type;

   typedef struct packed {
      logic [63:0] rem;
      logic [31:0] root;
   } sqrt_type;

   typedef struct packed {
      logic signed [35:0] x;
      logic signed [35:0] y;
      logic signed [35:0] z;
   } cordic_type;

   // one result bit of a floor square root, bit position k
   function automatic sqrt_type sqrt_step(sqrt_type cur, int k);
      logic [63:0] trial;
      sqrt_type    nxt;
      trial = ({32'd0, cur.root} << (k + 1)) | (64'd1 << (2 * k));
      nxt = cur;
      if (cur.rem >= trial) begin
         nxt.rem  = cur.rem - trial;
         nxt.root = cur.root | (32'd1 << k);
      end
      return nxt;
   endfunction

   // vectoring step: drives y toward zero, angle gathers in z
   function automatic cordic_type vec_step(cordic_type cur, int i);
      logic signed [35:0] dx;
      logic signed [35:0] dy;
      logic signed [35:0] at;
      cordic_type         nxt;
      dx = cur.y >>> i;
      dy = cur.x >>> i;
      at = $signed({4'd0, AtanTable[i]});
      if (cur.y > 36'sd0) begin
         nxt.x = cur.x + dx;
         nxt.y = cur.y - dy;
         nxt.z = cur.z + at;
      end else begin
         nxt.x = cur.x - dx;
         nxt.y = cur.y + dy;
         nxt.z = cur.z - at;
      end
      return nxt;
   endfunction

   // rotation step: drives z toward zero
   function automatic cordic_type rot_step(cordic_type cur, int i);
      logic signed [35:0] dx;
      logic signed [35:0] dy;
      logic signed [35:0] at;
      cordic_type         nxt;
      dx = cur.y >>> i;
      dy = cur.x >>> i;
      at = $signed({4'd0, AtanTable[i]});
      if (cur.z >= 36'sd0) begin
         nxt.x = cur.x - dx;
         nxt.y = cur.y + dy;
         nxt.z = cur.z - at;
      end else begin
         nxt.x = cur.x + dx;
         nxt.y = cur.y - dy;
         nxt.z = cur.z + at;
      end
      return nxt;
   endfunction

endpackage

`default_nettype wire

@@ hdl/qsl_norm.sv @@
// normalizer: scales the blended 4-vector, floor square root of the sum of squares,
// then a rounded restoring divide per component; uses qsl_pkg
`default_nettype none

module qsl_norm (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              blend_valid,
   input  wire logic [3:0][49:0]  blend_c,
   output logic                   rsp_valid,
   output qsl_pkg::rsp_type       rsp_item
);

   logic [qsl_pkg::NormStages-1:0] vld_ff;

   logic [3:0][49:0] mag1_ff, mag2_ff, mag3_ff, mag4_ff;
   logic [3:0]       neg1_ff, neg2_ff, neg3_ff, neg4_ff, neg5_ff, neg6_ff, neg7_ff;
   logic [49:0]      mxa2_ff, mxb2_ff, mx3_ff;
   logic [5:0]       lead_in, lead4_ff;
   logic             zero4_ff, zero5_ff, zero6_ff, zero7_ff;
   logic [3:0][29:0] sh5_ff, sh6_ff, sh7_ff;
   logic [3:0][59:0] sq6_ff;
   logic [60:0]      sa7_ff, sb7_ff;

   qsl_pkg::sqrt_type sqs_ff [qsl_pkg::RootBits+1];
   logic [3:0][29:0]  sqm_ff [qsl_pkg::RootBits+1];
   logic [3:0]        sqn_ff [qsl_pkg::RootBits+1];
   logic              sqz_ff [qsl_pkg::RootBits+1];

   logic [3:0][46:0]  dvr_ff [qsl_pkg::QuotBits+1];
   logic [3:0][15:0]  dvq_ff [qsl_pkg::QuotBits+1];
   logic [30:0]       dvd_ff [qsl_pkg::QuotBits+1];
   logic [3:0]        dvn_ff [qsl_pkg::QuotBits+1];
   logic              dvz_ff [qsl_pkg::QuotBits+1];

   qsl_pkg::rsp_type  rsp_ff;
   logic [3:0][15:0]  res_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[qsl_pkg::NormStages-2:0], blend_valid};
      end
   end

   always_comb begin
      lead_in = '0;
      for (int k = 0; k < 50; k++) begin
         if (mx3_ff[k]) begin
            lead_in = 6'(k);
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 4; k++) begin
         neg1_ff[k] <= blend_c[k][49];
         mag1_ff[k] <= blend_c[k][49] ? 50'(-$signed(blend_c[k])) : blend_c[k];
      end
      mag2_ff <= mag1_ff;
      neg2_ff <= neg1_ff;
      mxa2_ff <= (mag1_ff[0] > mag1_ff[1]) ? mag1_ff[0] : mag1_ff[1];
      mxb2_ff <= (mag1_ff[2] > mag1_ff[3]) ? mag1_ff[2] : mag1_ff[3];
      mag3_ff <= mag2_ff;
      neg3_ff <= neg2_ff;
      mx3_ff  <= (mxa2_ff > mxb2_ff) ? mxa2_ff : mxb2_ff;
      mag4_ff  <= mag3_ff;
      neg4_ff  <= neg3_ff;
      lead4_ff <= lead_in;
      zero4_ff <= (mx3_ff == '0);
      // bring the largest magnitude into [2^29, 2^30)
      for (int k = 0; k < 4; k++) begin
         if (lead4_ff >= 6'd29) begin
            sh5_ff[k] <= 30'(mag4_ff[k] >> (lead4_ff - 6'd29));
         end else begin
            sh5_ff[k] <= 30'(mag4_ff[k] << (6'd29 - lead4_ff));
         end
      end
      neg5_ff  <= neg4_ff;
      zero5_ff <= zero4_ff;
      for (int k = 0; k < 4; k++) begin
         sq6_ff[k] <= sh5_ff[k] * sh5_ff[k];
      end
      sh6_ff   <= sh5_ff;
      neg6_ff  <= neg5_ff;
      zero6_ff <= zero5_ff;
      sa7_ff   <= 61'(sq6_ff[0]) + 61'(sq6_ff[1]);
      sb7_ff   <= 61'(sq6_ff[2]) + 61'(sq6_ff[3]);
      sh7_ff   <= sh6_ff;
      neg7_ff  <= neg6_ff;
      zero7_ff <= zero6_ff;
   end

   // square root chain
   always_ff @(posedge clock) begin
      sqs_ff[0].rem  <= 64'(sa7_ff) + 64'(sb7_ff);
      sqs_ff[0].root <= '0;
      sqm_ff[0] <= sh7_ff;
      sqn_ff[0] <= neg7_ff;
      sqz_ff[0] <= zero7_ff;
      for (int g = 0; g < qsl_pkg::RootBits; g++) begin
         sqs_ff[g+1] <= qsl_pkg::sqrt_step(sqs_ff[g], qsl_pkg::RootBits - 1 - g);
         sqm_ff[g+1] <= sqm_ff[g];
         sqn_ff[g+1] <= sqn_ff[g];
         sqz_ff[g+1] <= sqz_ff[g];
      end
   end

   // rounded divide, one quotient bit per stage
   always_ff @(posedge clock) begin
      for (int k = 0; k < 4; k++) begin
         dvr_ff[0][k] <= 47'({sqm_ff[qsl_pkg::RootBits][k], qsl_pkg::FracBits'(0)})
                         + 47'(sqs_ff[qsl_pkg::RootBits].root >> 1);
      end
      dvq_ff[0] <= '0;
      dvd_ff[0] <= sqs_ff[qsl_pkg::RootBits].root[30:0];
      dvn_ff[0] <= sqn_ff[qsl_pkg::RootBits];
      dvz_ff[0] <= sqz_ff[qsl_pkg::RootBits];
      for (int g = 0; g < qsl_pkg::QuotBits; g++) begin
         for (int k = 0; k < 4; k++) begin
            if (dvr_ff[g][k] >= (47'(dvd_ff[g]) << (qsl_pkg::QuotBits - 1 - g))) begin
               dvr_ff[g+1][k] <= dvr_ff[g][k]
                                 - (47'(dvd_ff[g]) << (qsl_pkg::QuotBits - 1 - g));
               dvq_ff[g+1][k] <= dvq_ff[g][k] | (16'd1 << (qsl_pkg::QuotBits - 1 - g));
            end else begin
               dvr_ff[g+1][k] <= dvr_ff[g][k];
               dvq_ff[g+1][k] <= dvq_ff[g][k];
            end
         end
         dvd_ff[g+1] <= dvd_ff[g];
         dvn_ff[g+1] <= dvn_ff[g];
         dvz_ff[g+1] <= dvz_ff[g];
      end
   end

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         res_in[k] = (dvq_ff[qsl_pkg::QuotBits][k] > 16'd32767) ? 16'd32767
                     : dvq_ff[qsl_pkg::QuotBits][k];
         if (dvn_ff[qsl_pkg::QuotBits][k]) begin
            res_in[k] = 16'(-$signed(res_in[k]));
         end
         if (dvz_ff[qsl_pkg::QuotBits]) begin
            res_in[k] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff.out_w <= res_in[0];
      rsp_ff.out_x <= res_in[1];
      rsp_ff.out_y <= res_in[2];
      rsp_ff.out_z <= res_in[3];
   end

   assign rsp_valid = vld_ff[qsl_pkg::NormStages-1];
   assign rsp_item  = rsp_ff;

endmodule

`default_nettype wire

@@ hdl/quaternion_slerp_lerp.sv @@
// top level of the quaternion slerp / normalized lerp pipeline: dot product,
// acos by square root and vectoring cordic, sine weights, blend; uses qsl_pkg, qsl_norm
//
//   channel   ports                                   direction
//   request   start, busy, req_item                   in (busy out)
//   result    rsp_valid, rsp_item                     out
//   config    csr_write_en, csr_write_data            in
//
// one item per cycle while not in reset; the chain from accept to the rsp_valid cycle
// is set by two 31-stage square roots, a 30-stage vectoring cordic, a 30-stage
// rotation cordic pair and a 16-stage divider
// synchronous reset clears the valid chain and sets spherical mode; busy only
// during reset; results cannot be held off, so nothing in the pipeline stalls
`default_nettype none

module quaternion_slerp_lerp (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire qsl_pkg::req_type req_item,
   input  wire logic             csr_write_en,
   input  wire logic             csr_write_data,
   output logic                  rsp_valid,
   output qsl_pkg::rsp_type      rsp_item
);

   logic accept;
   logic mode_ff;
   logic [qsl_pkg::TopStages-1:0] vld_ff;

   qsl_pkg::work_type s1_in, w1_ff, w2_ff, w3_ff, w4_ff, w5_ff;
   qsl_pkg::work_type w4_in;
   logic signed [32:0] p2_ff [4];
   logic signed [34:0] d3_ff;
   logic        [34:0] dabs;
   logic               sph_in;
   logic        [30:0] d30_4_ff, d30_5_ff;
   logic        [61:0] dsq5_ff;

   qsl_pkg::sqrt_type   sqs_ff [qsl_pkg::RootBits+1];
   qsl_pkg::work_type   sqw_ff [qsl_pkg::RootBits+1];
   logic [30:0]         sqd_ff [qsl_pkg::RootBits+1];

   qsl_pkg::cordic_type vcs_ff [qsl_pkg::CordicSteps+1];
   qsl_pkg::work_type   vcw_ff [qsl_pkg::CordicSteps+1];

   qsl_pkg::work_type   thw_ff;
   logic signed [32:0]  thz_ff;
   logic signed [50:0]  thp_ff;
   logic signed [35:0]  a1_in;

   qsl_pkg::cordic_type r0_ff [qsl_pkg::CordicSteps+1];
   qsl_pkg::cordic_type r1_ff [qsl_pkg::CordicSteps+1];
   qsl_pkg::work_type   rtw_ff [qsl_pkg::CordicSteps+1];

   logic signed [31:0]  m0_in, m1_in;
   logic signed [48:0]  pa_ff [4];
   logic signed [48:0]  pb_ff [4];
   logic [3:0][49:0]    c_ff;

   assign busy   = reset;
   assign accept = start & ~busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b1;
         vld_ff  <= '0;
      end else begin
         if (csr_write_en) begin
            mode_ff <= csr_write_data;
         end
         vld_ff <= {vld_ff[qsl_pkg::TopStages-2:0], accept};
      end
   end

   always_comb begin
      s1_in.t = (req_item.fraction > 17'(qsl_pkg::OneQ16)) ? 17'(qsl_pkg::OneQ16)
                : req_item.fraction;
      s1_in.a = {req_item.from_z, req_item.from_y, req_item.from_x, req_item.from_w};
      s1_in.b = {17'(req_item.to_z), 17'(req_item.to_y),
                 17'(req_item.to_x), 17'(req_item.to_w)};
      s1_in.sph = mode_ff;
   end

   // dot product, shorter arc, path select
   always_comb begin
      dabs   = d3_ff[34] ? 35'(-d3_ff) : 35'(d3_ff);
      sph_in = w3_ff.sph && (dabs <= qsl_pkg::Thresh);
      w4_in  = w3_ff;
      for (int k = 0; k < 4; k++) begin
         w4_in.b[k] = d3_ff[34] ? 17'(-$signed(w3_ff.b[k])) : w3_ff.b[k];
      end
      w4_in.sph = sph_in;
   end

   always_ff @(posedge clock) begin
      w1_ff <= s1_in;
      w2_ff <= w1_ff;
      for (int k = 0; k < 4; k++) begin
         p2_ff[k] <= 33'($signed(w1_ff.a[k]) * $signed(w1_ff.b[k]));
      end
      w3_ff <= w2_ff;
      d3_ff <= 35'(p2_ff[0]) + 35'(p2_ff[1]) + 35'(p2_ff[2]) + 35'(p2_ff[3]);
      w4_ff     <= w4_in;
      d30_4_ff  <= sph_in ? 31'(dabs << qsl_pkg::D30Shift) : '0;
      w5_ff    <= w4_ff;
      d30_5_ff <= d30_4_ff;
      dsq5_ff  <= d30_4_ff * d30_4_ff;
   end

   // sine of the angle: sqrt(1 - d^2)
   always_ff @(posedge clock) begin
      sqs_ff[0].rem  <= (64'd1 << (2 * qsl_pkg::AngleFrac)) - 64'(dsq5_ff);
      sqs_ff[0].root <= '0;
      sqw_ff[0] <= w5_ff;
      sqd_ff[0] <= d30_5_ff;
      for (int g = 0; g < qsl_pkg::RootBits; g++) begin
         sqs_ff[g+1] <= qsl_pkg::sqrt_step(sqs_ff[g], qsl_pkg::RootBits - 1 - g);
         sqw_ff[g+1] <= sqw_ff[g];
         sqd_ff[g+1] <= sqd_ff[g];
      end
   end

   // theta = atan2(sine, cosine)
   always_ff @(posedge clock) begin
      vcs_ff[0].x <= $signed({5'd0, sqd_ff[qsl_pkg::RootBits]});
      vcs_ff[0].y <= $signed({4'd0, sqs_ff[qsl_pkg::RootBits].root});
      vcs_ff[0].z <= '0;
      vcw_ff[0]   <= sqw_ff[qsl_pkg::RootBits];
      for (int g = 0; g < qsl_pkg::CordicSteps; g++) begin
         vcs_ff[g+1] <= qsl_pkg::vec_step(vcs_ff[g], g);
         vcw_ff[g+1] <= vcw_ff[g];
      end
   end

   always_ff @(posedge clock) begin
      thw_ff <= vcw_ff[qsl_pkg::CordicSteps];
      thz_ff <= vcs_ff[qsl_pkg::CordicSteps].z[32:0];
      thp_ff <= $signed(vcs_ff[qsl_pkg::CordicSteps].z[32:0])
                * $signed({1'b0, vcw_ff[qsl_pkg::CordicSteps].t});
   end

   assign a1_in = 36'(thp_ff >>> 16);

   // weights sin((1-t)theta) and sin(t theta)
   always_ff @(posedge clock) begin
      r0_ff[0].x <= 36'sd1 <<< (qsl_pkg::AngleFrac - 2);
      r0_ff[0].y <= '0;
      r0_ff[0].z <= 36'(thz_ff) - a1_in;
      r1_ff[0].x <= 36'sd1 <<< (qsl_pkg::AngleFrac - 2);
      r1_ff[0].y <= '0;
      r1_ff[0].z <= a1_in;
      rtw_ff[0]  <= thw_ff;
      for (int g = 0; g < qsl_pkg::CordicSteps; g++) begin
         r0_ff[g+1]  <= qsl_pkg::rot_step(r0_ff[g], g);
         r1_ff[g+1]  <= qsl_pkg::rot_step(r1_ff[g], g);
         rtw_ff[g+1] <= rtw_ff[g];
      end
   end

   always_comb begin
      if (rtw_ff[qsl_pkg::CordicSteps].sph) begin
         m0_in = 32'(r0_ff[qsl_pkg::CordicSteps].y);
         m1_in = 32'(r1_ff[qsl_pkg::CordicSteps].y);
      end else begin
         m0_in = $signed({15'd0, 17'(17'(qsl_pkg::OneQ16) - rtw_ff[qsl_pkg::CordicSteps].t)});
         m1_in = $signed({15'd0, rtw_ff[qsl_pkg::CordicSteps].t});
      end
   end

   // blend
   always_ff @(posedge clock) begin
      for (int k = 0; k < 4; k++) begin
         pa_ff[k] <= 49'($signed(rtw_ff[qsl_pkg::CordicSteps].a[k]) * m0_in);
         pb_ff[k] <= 49'($signed(rtw_ff[qsl_pkg::CordicSteps].b[k]) * m1_in);
      end
      for (int k = 0; k < 4; k++) begin
         c_ff[k] <= 50'(50'(pa_ff[k]) + 50'(pb_ff[k]));
      end
   end

   qsl_norm u_norm (
      .clock       (clock),
      .reset       (reset),
      .blend_valid (vld_ff[qsl_pkg::TopStages-1]),
      .blend_c     (c_ff),
      .rsp_valid   (rsp_valid),
      .rsp_item    (rsp_item)
   );

endmodule

`default_nettype wire

@@ hdl/qsl_checker.sv @@
// port-level checks for quaternion_slerp_lerp, attached by bind
// uses qsl_pkg for the fixed pipeline latency
`default_nettype none

module qsl_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             start,
   input wire logic             busy,
   input wire qsl_pkg::req_type req_item,
   input wire logic             rsp_valid,
   input wire qsl_pkg::rsp_type rsp_item
);

   logic zero_req;
   logic zero_rsp;

   assign zero_req = (req_item.from_w == '0) && (req_item.from_x == '0)
                     && (req_item.from_y == '0) && (req_item.from_z == '0)
                     && (req_item.to_w == '0) && (req_item.to_x == '0)
                     && (req_item.to_y == '0) && (req_item.to_z == '0);
   assign zero_rsp = (rsp_item.out_w == '0) && (rsp_item.out_x == '0)
                     && (rsp_item.out_y == '0) && (rsp_item.out_z == '0);

   // no result in the cycle after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result right after reset");

   // every result comes from an item accepted a fixed latency earlier
   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, qsl_pkg::Latency))
      else $error("result without matching item");

   // a unit result never leaves the unit range
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_item.out_w >= -16'sd16384) && (rsp_item.out_w <= 16'sd16384)
                 && (rsp_item.out_x >= -16'sd16384) && (rsp_item.out_x <= 16'sd16384)
                 && (rsp_item.out_y >= -16'sd16384) && (rsp_item.out_y <= 16'sd16384)
                 && (rsp_item.out_z >= -16'sd16384) && (rsp_item.out_z <= 16'sd16384))
      else $error("result component out of range");

   // all-zero quaternions blend to an all-zero result
   a_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && $past(start && !busy && zero_req, qsl_pkg::Latency)) |-> zero_rsp)
      else $error("zero item gave nonzero result");

endmodule

bind quaternion_slerp_lerp qsl_checker u_qsl_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_item  (req_item),
   .rsp_valid (rsp_valid),
   .rsp_item  (rsp_item)
);

`default_nettype wire

@@ test/quaternion_slerp_lerp_test.sv @@
// testbench for quaternion_slerp_lerp: directed and random interpolation items in both modes,
// checked against an in-bench bit-exact slerp / normalized lerp predictor
// depends on qsl_pkg and the quaternion_slerp_lerp rtl
`timescale 1ns / 1ps

module quaternion_slerp_lerp_test;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   qsl_pkg::req_type req_item = '0;
   logic             csr_write_en = 1'b0;
   logic             csr_write_data = 1'b0;
   logic             rsp_valid;
   qsl_pkg::rsp_type rsp_item;

   qsl_pkg::rsp_type expected_quats[$];
   bit      mode_shadow = 1'b1;
   int      mismatches = 0;
   int      burst_left = 0;

   always #4 clock = ~clock;

   quaternion_slerp_lerp i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_item(req_item),
      .csr_write_en(csr_write_en), .csr_write_data(csr_write_data),
      .rsp_valid(rsp_valid), .rsp_item(rsp_item)
   );

   function automatic longint unsigned root_floor(longint unsigned v);
      longint unsigned r;
      longint unsigned bitv;
      r = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= r + bitv) begin
            v -= r + bitv;
            r = (r >> 1) + bitv;
         end else begin
            r >>= 1;
         end
         bitv >>= 2;
      end
      return r;
   endfunction

   function automatic longint arc_angle(longint x, longint y);
      longint z;
      longint dx;
      longint dy;
      z = 0;
      for (int i = 0; i < qsl_pkg::CordicSteps; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y > 0) begin
            x += dx; y -= dy; z += longint'(qsl_pkg::AtanTable[i]);
         end else begin
            x -= dx; y += dy; z -= longint'(qsl_pkg::AtanTable[i]);
         end
      end
      return z;
   endfunction

   function automatic longint scaled_sine(longint z);
      longint x;
      longint y;
      longint dx;
      longint dy;
      x = 64'sd1 <<< 28;
      y = 0;
      for (int i = 0; i < qsl_pkg::CordicSteps; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx; y += dy; z -= longint'(qsl_pkg::AtanTable[i]);
         end else begin
            x += dx; y -= dy; z += longint'(qsl_pkg::AtanTable[i]);
         end
      end
      return y;
   endfunction

   function automatic qsl_pkg::rsp_type interpolate(qsl_pkg::req_type r, bit sph);
      longint a[4];
      longint b[4];
      longint c[4];
      longint d;
      longint t;
      longint one;
      longint thresh;
      longint theta;
      longint a1;
      longint w0;
      longint w1;
      longint unsigned d30;
      longint unsigned s30;
      longint unsigned mag[4];
      longint unsigned mx;
      longint unsigned sum;
      longint unsigned n;
      longint unsigned q;
      logic signed [15:0] o[4];
      qsl_pkg::rsp_type res;
      t = r.fraction;
      if (t > qsl_pkg::OneQ16) t = qsl_pkg::OneQ16;
      a[0] = r.from_w; a[1] = r.from_x; a[2] = r.from_y; a[3] = r.from_z;
      b[0] = r.to_w;   b[1] = r.to_x;   b[2] = r.to_y;   b[3] = r.to_z;
      d = 0;
      for (int k = 0; k < 4; k++) d += a[k] * b[k];
      if (d < 0) begin
         d = -d;
         for (int k = 0; k < 4; k++) b[k] = -b[k];
      end
      one = 64'sd1 <<< (2 * qsl_pkg::FracBits);
      thresh = one - one / 200000;
      if (sph && d <= thresh) begin
         d30 = longint'(d) << (30 - 2 * qsl_pkg::FracBits);
         s30 = root_floor((64'd1 << 60) - d30 * d30);
         theta = arc_angle(longint'(d30), longint'(s30));
         a1 = (theta * t) >>> 16;
         w1 = scaled_sine(a1);
         w0 = scaled_sine(theta - a1);
         for (int k = 0; k < 4; k++) c[k] = a[k] * w0 + b[k] * w1;
      end else begin
         for (int k = 0; k < 4; k++) c[k] = a[k] * (qsl_pkg::OneQ16 - t) + b[k] * t;
      end
      mx = 0;
      for (int k = 0; k < 4; k++) begin
         mag[k] = c[k] < 0 ? longint'(-c[k]) : longint'(c[k]);
         if (mag[k] > mx) mx = mag[k];
      end
      if (mx == 0) begin
         return '0;
      end
      while (mx >= (64'd1 << 30)) begin
         mx >>= 1;
         for (int k = 0; k < 4; k++) mag[k] >>= 1;
      end
      while (mx < (64'd1 << 29)) begin
         mx <<= 1;
         for (int k = 0; k < 4; k++) mag[k] <<= 1;
      end
      sum = 0;
      for (int k = 0; k < 4; k++) sum += mag[k] * mag[k];
      n = root_floor(sum);
      for (int k = 0; k < 4; k++) begin
         q = ((mag[k] << qsl_pkg::FracBits) + n / 2) / n;
         if (q > 32767) q = 32767;
         o[k] = c[k] < 0 ? -16'(q) : 16'(q);
      end
      res.out_w = o[0]; res.out_x = o[1]; res.out_y = o[2]; res.out_z = o[3];
      return res;
   endfunction

   // predict on accept, track the mode register
   always @(posedge clock) begin
      if (!reset && start && !busy) expected_quats.push_back(interpolate(req_item, mode_shadow));
      if (reset) mode_shadow = 1'b1;
      else if (csr_write_en) mode_shadow = csr_write_data;
   end

   always @(posedge clock) begin
      qsl_pkg::rsp_type want;
      if (!reset && rsp_valid) begin
         if (expected_quats.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected item %h", rsp_item);
         end else begin
            want = expected_quats.pop_front();
            if (want.out_w !== rsp_item.out_w || want.out_x !== rsp_item.out_x ||
                want.out_y !== rsp_item.out_y || want.out_z !== rsp_item.out_z) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch exp w%0d x%0d y%0d z%0d got w%0d x%0d y%0d z%0d",
                           want.out_w, want.out_x, want.out_y, want.out_z,
                           rsp_item.out_w, rsp_item.out_x, rsp_item.out_y, rsp_item.out_z);
            end
         end
      end
   end

   task automatic send_item(qsl_pkg::req_type it);
      start <= 1'b1;
      req_item <= it;
      @(posedge clock);
      while (busy) @(posedge clock);
      if (burst_left == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 6);
      end else begin
         burst_left--;
      end
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      @(posedge clock);
      while (expected_quats.size() != 0) @(posedge clock);
   endtask

   task automatic set_mode(bit m);
      wait_drained();
      csr_write_en <= 1'b1;
      csr_write_data <= m;
      @(posedge clock);
      csr_write_en <= 1'b0;
      @(posedge clock);
   endtask

   function automatic qsl_pkg::req_type make_item(int t, int fw, int fx, int fy, int fz,
                                                  int tw, int tx, int ty, int tz);
      qsl_pkg::req_type r;
      r.fraction = 17'(t);
      r.from_w = 16'(fw); r.from_x = 16'(fx); r.from_y = 16'(fy); r.from_z = 16'(fz);
      r.to_w = 16'(tw);   r.to_x = 16'(tx);   r.to_y = 16'(ty);   r.to_z = 16'(tz);
      return r;
   endfunction

   task automatic unit_quat(output int q[4]);
      real v[4];
      real norm;
      norm = 0.0;
      for (int k = 0; k < 4; k++) begin
         v[k] = real'(int'($urandom_range(0, 65535)) - 32768);
         norm += v[k] * v[k];
      end
      if (norm == 0.0) begin
         v[0] = 1.0;
         norm = 1.0;
      end
      norm = $sqrt(norm);
      for (int k = 0; k < 4; k++) q[k] = $rtoi(v[k] * 16384.0 / norm);
   endtask

   function automatic int rand_fraction();
      if ($urandom_range(0, 9) == 0) return $urandom_range(0, 131071);
      return $urandom_range(0, 65536);
   endfunction

   task automatic test_directed();
      send_item(make_item(0, 16384, 0, 0, 0, 0, 16384, 0, 0));
      send_item(make_item(65536, 16384, 0, 0, 0, 0, 16384, 0, 0));
      send_item(make_item(32768, 16384, 0, 0, 0, 0, 16384, 0, 0));
      send_item(make_item(131071, 16384, 0, 0, 0, 0, 0, 16384, 0));
      send_item(make_item(65537, 0, 0, 0, 16384, 0, 16384, 0, 0));
      send_item(make_item(16384, 16384, 0, 0, 0, 16384, 0, 0, 0));
      send_item(make_item(40000, 16384, 0, 0, 0, 16383, 181, 0, 0));
      send_item(make_item(12345, 16384, 0, 0, 0, -16384, 0, 0, 0));
      send_item(make_item(50000, 16384, 0, 0, 0, -11585, 11585, 0, 0));
      send_item(make_item(0, 0, 0, 0, 0, 16384, 0, 0, 0));
      send_item(make_item(7000, 0, 0, 0, 0, 0, 0, 0, 0));
      send_item(make_item(32768, -16384, -16384, -16384, -16384, 16384, 16384, 16384, 16384));
      send_item(make_item(32768, 32767, 32767, 32767, 32767, -32768, -32768, -32768, -32768));
      send_item(make_item(100, 2000, 1000, -500, 300, 1000, -2000, 300, 500));
      send_item(make_item(65535, 8192, 8192, 8192, 8192, 8192, -8192, 8192, -8192));
      send_item(make_item(1, -32768, 0, 0, 0, 0, 0, 0, 32767));
   endtask

   task automatic test_random(int count);
      int p[4];
      int q[4];
      qsl_pkg::req_type r;
      for (int i = 0; i < count; i++) begin
         unit_quat(p);
         case ($urandom_range(0, 19))
            0, 1, 2: begin
               for (int k = 0; k < 4; k++) q[k] = p[k] + int'($urandom_range(0, 8)) - 4;
               if ($urandom_range(0, 1)) for (int k = 0; k < 4; k++) q[k] = -q[k];
            end
            3, 4, 5: begin
               r = qsl_pkg::req_type'({$urandom, $urandom, $urandom, $urandom, $urandom});
               r.fraction = 17'(rand_fraction());
               send_item(r);
               continue;
            end
            default: unit_quat(q);
         endcase
         send_item(make_item(rand_fraction(), p[0], p[1], p[2], p[3], q[0], q[1], q[2], q[3]));
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      set_mode(1'b0);
      test_directed();
      test_random(200);
      set_mode(1'b1);
      test_random(250);
      wait_drained();
      repeat ($urandom_range(1, 40)) @(posedge clock);
      test_random(150);
      wait_drained();
      repeat (qsl_pkg::Latency + 20) @(posedge clock);
      if (mismatches == 0 && expected_quats.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #4000000;
      $display("== FAIL ==");
      $finish;
   end

endmodule

@@ files.f @@
hdl/qsl_pkg.sv
hdl/qsl_norm.sv
hdl/quaternion_slerp_lerp.sv
hdl/qsl_checker.sv
test/quaternion_slerp_lerp_test.sv
